// ----- rtl/pbrd_pkg.sv -----
// pbrd_pkg: shared types and constants of the packbits run decoder
// no dependencies; used by the interfaces, pbrd_step and the top level

package pbrd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 8;
    localparam int unsigned COUNT_W  = 25;

    localparam logic [BYTE_W-1:0]  HDR_END       = 8'd128;
    localparam logic [8:0]         REPEAT_BASE   = 9'd257;
    localparam logic [COUNT_W-1:0] LIMIT_DEFAULT = 25'd65536;

    typedef enum logic [1:0] {
        MODE_HEADER  = 2'd0,
        MODE_LITERAL = 2'd1,
        MODE_VALUE   = 2'd2,
        MODE_STOPPED = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        END_MARKER    = 2'd0,
        END_REFUSED   = 2'd1,
        END_FILLED    = 2'd2,
        END_EXHAUSTED = 2'd3
    } t_reason;

    typedef struct packed {
        t_mode              mode;
        logic [LEN_W-1:0]   literal_left;
        logic [LEN_W-1:0]   repeat_count;
        logic [COUNT_W-1:0] produced;
    } t_state;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              segment_start;
        logic              last_byte;
    } t_in;

    typedef struct packed {
        logic [BYTE_W-1:0]  run_byte;
        logic [LEN_W-1:0]   run_length;
        logic               done_res;
        t_reason            end_reason;
        logic [COUNT_W-1:0] total_bytes;
    } t_res;

endpackage

// ----- rtl/pbrd_if.sv -----
// pbrd channel interfaces: compressed byte input, run output, limit write
// depends on pbrd_pkg for field widths

interface pbrd_in_if;
    logic                          valid;
    logic                          ready;
    logic [pbrd_pkg::BYTE_W-1:0]   data_byte;
    logic                          segment_start;
    logic                          last_byte;

    modport source (output valid, data_byte, segment_start, last_byte, input ready);
    modport sink   (input valid, data_byte, segment_start, last_byte, output ready);
endinterface

interface pbrd_out_if;
    logic                          valid;
    logic                          ready;
    logic [pbrd_pkg::BYTE_W-1:0]   run_byte;
    logic [pbrd_pkg::LEN_W-1:0]    run_length;
    logic                          done_res;
    logic [1:0]                    end_reason;
    logic [pbrd_pkg::COUNT_W-1:0]  total_bytes;

    modport source (output valid, run_byte, run_length, done_res, end_reason, total_bytes,
                    input ready);
    modport sink   (input valid, run_byte, run_length, done_res, end_reason, total_bytes,
                    output ready);
endinterface

interface pbrd_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [pbrd_pkg::COUNT_W-1:0]  output_limit;

    modport source (output valid, output_limit, input ready);
    modport sink   (input valid, output_limit, output ready);
endinterface

// ----- rtl/pbrd_step.sv -----
// pbrd_step: decodes one compressed byte against the current segment state
// combinational; depends on pbrd_pkg

module pbrd_step (
    input  pbrd_pkg::t_state                i_state,
    input  logic [pbrd_pkg::COUNT_W-1:0]    i_limit,
    input  pbrd_pkg::t_in                   i_word,
    output pbrd_pkg::t_state                o_state,
    output logic                            o_emit,
    output pbrd_pkg::t_res                  o_res
);

    pbrd_pkg::t_state                st;
    logic [pbrd_pkg::LEN_W-1:0]      count;
    logic [pbrd_pkg::COUNT_W:0]      sum_hdr;
    logic [pbrd_pkg::COUNT_W:0]      sum_run;
    logic [pbrd_pkg::LEN_W-1:0]      run_len;
    logic                            have_run;
    logic                            done;
    logic                            stopped;
    pbrd_pkg::t_reason               reason;

    always_comb begin
        st = i_state;
        if (i_word.segment_start) begin
            st.mode         = pbrd_pkg::MODE_HEADER;
            st.literal_left = '0;
            st.repeat_count = '0;
            st.produced     = '0;
        end
    end

    // run length announced by a header byte
    always_comb begin
        logic [8:0] rep;
        rep = pbrd_pkg::REPEAT_BASE - {1'b0, i_word.data_byte};
        if (i_word.data_byte < pbrd_pkg::HDR_END) begin
            count = i_word.data_byte + 8'd1;
        end else begin
            count = rep[pbrd_pkg::LEN_W-1:0];
        end
    end

    assign sum_hdr = {1'b0, st.produced} + {{(pbrd_pkg::COUNT_W+1-pbrd_pkg::LEN_W){1'b0}}, count};
    assign run_len = (st.mode == pbrd_pkg::MODE_LITERAL) ? 8'd1 : st.repeat_count;
    assign sum_run = {1'b0, st.produced}
                   + {{(pbrd_pkg::COUNT_W+1-pbrd_pkg::LEN_W){1'b0}}, run_len};

    always_comb begin
        o_state  = st;
        have_run = 1'b0;
        done     = 1'b0;
        stopped  = 1'b0;
        reason   = pbrd_pkg::END_MARKER;
        unique case (st.mode)
            pbrd_pkg::MODE_HEADER: begin
                if (st.produced >= i_limit) begin
                    done   = 1'b1;
                    reason = pbrd_pkg::END_FILLED;
                end else if (i_word.data_byte == pbrd_pkg::HDR_END) begin
                    done   = 1'b1;
                    reason = pbrd_pkg::END_MARKER;
                end else if (sum_hdr > {1'b0, i_limit}) begin
                    done   = 1'b1;
                    reason = pbrd_pkg::END_REFUSED;
                end else if (i_word.data_byte < pbrd_pkg::HDR_END) begin
                    o_state.literal_left = count;
                    o_state.mode         = pbrd_pkg::MODE_LITERAL;
                end else begin
                    o_state.repeat_count = count;
                    o_state.mode         = pbrd_pkg::MODE_VALUE;
                end
            end
            pbrd_pkg::MODE_LITERAL: begin
                have_run         = 1'b1;
                o_state.produced = sum_run[pbrd_pkg::COUNT_W-1:0];
                if (st.literal_left <= 8'd1) begin
                    o_state.literal_left = '0;
                    o_state.mode         = pbrd_pkg::MODE_HEADER;
                end else begin
                    o_state.literal_left = st.literal_left - 8'd1;
                end
            end
            pbrd_pkg::MODE_VALUE: begin
                have_run             = 1'b1;
                o_state.produced     = sum_run[pbrd_pkg::COUNT_W-1:0];
                o_state.repeat_count = '0;
                o_state.mode         = pbrd_pkg::MODE_HEADER;
            end
            pbrd_pkg::MODE_STOPPED: begin
                stopped = 1'b1;
            end
            default: begin
                stopped = 1'b1;
            end
        endcase

        // filled limit outranks input exhausted
        if (have_run && (o_state.produced >= i_limit)) begin
            done   = 1'b1;
            reason = pbrd_pkg::END_FILLED;
        end
        if (!stopped && !done && i_word.last_byte) begin
            done   = 1'b1;
            reason = pbrd_pkg::END_EXHAUSTED;
        end
        if (done) begin
            o_state.mode         = pbrd_pkg::MODE_STOPPED;
            o_state.literal_left = '0;
            o_state.repeat_count = '0;
        end
    end

    assign o_emit           = have_run || done;
    assign o_res.run_byte   = have_run ? i_word.data_byte : '0;
    assign o_res.run_length = have_run ? run_len : '0;
    assign o_res.done_res   = done;
    assign o_res.end_reason = reason;
    assign o_res.total_bytes = o_state.produced;

endmodule

// ----- rtl/packbits_run_decoder_core.sv -----
// packbits_run_decoder_core: top level; depends on pbrd_pkg, pbrd_if, pbrd_step
// an accepted word is held in the input register; any run it yields goes on to
// the output register. throughput: one compressed byte per cycle unless the
// output stalls; decode is combinational in pbrd_step, between the two registers
// reset: synchronous active-low; clears valids, decode state, limit to 65536

module packbits_run_decoder_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pbrd_in_if.sink           i_in,
    pbrd_cfg_if.sink          i_cfg,
    pbrd_out_if.source        o_out
);

    logic                           r_s1_valid;
    pbrd_pkg::t_in                  r_s1;
    pbrd_pkg::t_state               r_state;
    logic [pbrd_pkg::COUNT_W-1:0]   r_limit;
    logic                           r_out_valid;
    pbrd_pkg::t_res                 r_out;

    pbrd_pkg::t_state               n_state;
    pbrd_pkg::t_res                 n_out;
    logic                           step_emit;
    logic                           s2_take;
    logic                           s1_load;

    // the stage-1 word retires when the output register is free or draining
    assign s2_take = r_s1_valid && (!r_out_valid || o_out.ready);
    assign s1_load = !r_s1_valid || s2_take;

    assign i_in.ready  = s1_load;
    assign i_cfg.ready = 1'b1;

    pbrd_step u_step (
        .i_state (r_state),
        .i_limit (r_limit),
        .i_word  (r_s1),
        .o_state (n_state),
        .o_emit  (step_emit),
        .o_res   (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid           <= 1'b0;
            r_out_valid          <= 1'b0;
            r_limit              <= pbrd_pkg::LIMIT_DEFAULT;
            r_state.mode         <= pbrd_pkg::MODE_HEADER;
            r_state.literal_left <= '0;
            r_state.repeat_count <= '0;
            r_state.produced     <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_limit <= i_cfg.output_limit;
            end
            if (s1_load) begin
                r_s1_valid <= i_in.valid;
            end
            if (s2_take) begin
                r_state     <= n_state;
                r_out_valid <= step_emit;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load && i_in.valid) begin
            r_s1.data_byte     <= i_in.data_byte;
            r_s1.segment_start <= i_in.segment_start;
            r_s1.last_byte     <= i_in.last_byte;
        end
        if (s2_take && step_emit) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.run_byte    = r_out.run_byte;
    assign o_out.run_length  = r_out.run_length;
    assign o_out.done_res    = r_out.done_res;
    assign o_out.end_reason  = r_out.end_reason;
    assign o_out.total_bytes = r_out.total_bytes;

endmodule
